### rtl/integer_matrix_multiply_assert.svh
// Assertion macros for the integer matrix multiplier.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/imm_pkg.sv
// Shared types and codes for the integer matrix multiplier.
// No dependencies.
package imm_pkg;

    // Element and result word width
    localparam int DATA_W = 32;
    // Width of a dimension register
    localparam int DIM_W  = 4;

    // Item action codes
    localparam logic [1:0] ACT_WR_A    = 2'd0;
    localparam logic [1:0] ACT_WR_B    = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } state_t;

endpackage

### rtl/imm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### rtl/integer_matrix_multiply.sv
// Integer matrix multiplier top level.
// Depends on imm_pkg, imm_ram and integer_matrix_multiply_assert.svh.
//
// Load items (write A or B element) are taken one per cycle while idle. A
// compute item walks the product in row-major order; for each product element
// the terms are read from the A and B RAMs one per cycle, the read data and
// then the product are registered and summed, and the result is held on the
// output until taken. A run is paced by the single shared 32x32 multiplier and
// the one read port of each matrix RAM. item_ready is low for the whole run.
// Element reads of A and B that were never written return whatever the RAM
// holds.
`include "integer_matrix_multiply_assert.svh"

module integer_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]          cfg_data,
    // Input item channel
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [1:0]                         action,
    input  logic [2:0]                         row_index,
    input  logic [2:0]                         col_index,
    input  logic signed [imm_pkg::DATA_W-1:0]  element_value,
    // Result item channel
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [2:0]                         out_row,
    output logic [2:0]                         out_col,
    output logic signed [imm_pkg::DATA_W-1:0]  product_value,
    output logic                               last
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    // Clamp a dimension register to 1..MAX_DIM and return it minus one
    function automatic logic [IDX_W-1:0] clamp_m1(input logic [imm_pkg::DIM_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v == '0)
        begin
            r = '0;
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = IDX_W'(32'(v) - 1);
        end
        return r;
    endfunction

    imm_pkg::state_t state_reg, state_next;

    logic [imm_pkg::DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;

    logic [IDX_W-1:0] nr_m1_reg, nr_m1_next;
    logic [IDX_W-1:0] nk_m1_reg, nk_m1_next;
    logic [IDX_W-1:0] nc_m1_reg, nc_m1_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic rd_vld_reg, rd_last_reg;
    logic prod_vld_reg, prod_last_reg;

    logic [imm_pkg::DATA_W-1:0] prod_reg;
    logic [imm_pkg::DATA_W-1:0] acc_reg;
    logic [imm_pkg::DATA_W-1:0] result_reg;

    logic                       item_acc;
    logic                       compute_acc;
    logic                       wr_in_range;
    logic                       wr_a_en, wr_b_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr_a, rd_addr_b;
    logic [imm_pkg::DATA_W-1:0] rd_data_a, rd_data_b;
    logic [imm_pkg::DATA_W-1:0] mul_lo;
    logic [imm_pkg::DATA_W-1:0] acc_sum;
    logic                       is_last;

    // Handshake decode
    assign item_acc    = item_valid && item_ready;
    assign compute_acc = item_acc && (action == imm_pkg::ACT_COMPUTE);
    assign wr_in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
    assign wr_addr     = ADDR_W'(32'(row_index) * MAX_DIM + 32'(col_index));
    assign wr_a_en     = item_acc && wr_in_range && (action == imm_pkg::ACT_WR_A);
    assign wr_b_en     = item_acc && wr_in_range && (action == imm_pkg::ACT_WR_B);

    // Term addresses: A[i][k] and B[k][j]
    assign rd_addr_a = ADDR_W'(32'(i_reg) * MAX_DIM + 32'(k_reg));
    assign rd_addr_b = ADDR_W'(32'(k_reg) * MAX_DIM + 32'(j_reg));

    imm_ram #(
        .WIDTH (imm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a_en),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    imm_ram #(
        .WIDTH (imm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b_en),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // Shared multiplier, low word only (wraps modulo 2^32)
    assign mul_lo  = rd_data_a * rd_data_b;
    assign acc_sum = acc_reg + prod_reg;
    assign is_last = (i_reg == nr_m1_reg) && (j_reg == nc_m1_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imm_pkg::ST_IDLE:
            begin
                if (compute_acc)
                begin
                    state_next = imm_pkg::ST_ISSUE;
                end
            end
            imm_pkg::ST_ISSUE:
            begin
                if (k_reg == nk_m1_reg)
                begin
                    state_next = imm_pkg::ST_DRAIN;
                end
            end
            imm_pkg::ST_DRAIN:
            begin
                if (prod_last_reg)
                begin
                    state_next = imm_pkg::ST_OUT;
                end
            end
            imm_pkg::ST_OUT:
            begin
                if (result_ready)
                begin
                    state_next = is_last ? imm_pkg::ST_IDLE : imm_pkg::ST_ISSUE;
                end
            end
            default:
            begin
                state_next = imm_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        item_ready   = 1'b0;
        result_valid = 1'b0;
        rd_en        = 1'b0;
        case (state_reg)
            imm_pkg::ST_IDLE:  item_ready   = 1'b1;
            imm_pkg::ST_ISSUE: rd_en        = 1'b1;
            imm_pkg::ST_OUT:   result_valid = 1'b1;
            default:           item_ready   = 1'b0;
        endcase
    end

    // Loop counters and latched dimensions
    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        nr_m1_next = nr_m1_reg;
        nk_m1_next = nk_m1_reg;
        nc_m1_next = nc_m1_reg;
        if (compute_acc)
        begin
            i_next     = '0;
            j_next     = '0;
            k_next     = '0;
            nr_m1_next = clamp_m1(rows_a_reg);
            nk_m1_next = clamp_m1(inner_dim_reg);
            nc_m1_next = clamp_m1(cols_b_reg);
        end
        else if (state_reg == imm_pkg::ST_ISSUE)
        begin
            k_next = (k_reg == nk_m1_reg) ? '0 : k_reg + 1'b1;
        end
        else if (state_reg == imm_pkg::ST_OUT && result_ready && !is_last)
        begin
            if (j_reg == nc_m1_reg)
            begin
                j_next = '0;
                i_next = i_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imm_pkg::ST_IDLE;
            rows_a_reg    <= imm_pkg::DIM_W'(8);
            inner_dim_reg <= imm_pkg::DIM_W'(8);
            cols_b_reg    <= imm_pkg::DIM_W'(8);
            nr_m1_reg     <= '0;
            nk_m1_reg     <= '0;
            nc_m1_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nr_m1_reg     <= nr_m1_next;
            nk_m1_reg     <= nk_m1_next;
            nc_m1_reg     <= nc_m1_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            // Advance the read and multiply valid pipeline
            rd_vld_reg    <= rd_en;
            rd_last_reg   <= rd_en && (k_reg == nk_m1_reg);
            prod_vld_reg  <= rd_vld_reg;
            prod_last_reg <= rd_last_reg;
            // Take configuration writes; drop unknown indexes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    imm_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                    imm_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                    imm_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                    default:                rows_a_reg    <= rows_a_reg;
                endcase
            end
        end
    end

    // Product, accumulator and result word
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= mul_lo;
        end
        if (prod_last_reg)
        begin
            result_reg <= acc_sum;
            acc_reg    <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_sum;
        end
        else if (compute_acc)
        begin
            acc_reg <= '0;
        end
    end

    // Result fields
    assign out_row       = 3'(i_reg);
    assign out_col       = 3'(j_reg);
    assign product_value = result_reg;
    assign last          = is_last;

    // Intake is closed while a result waits
    `IMM_ASSERT_SAME(a_no_intake_with_result, item_ready, !result_valid, "intake open with result pending")
    // Multiply pipeline is only busy during a run
    `IMM_ASSERT_SAME(a_prod_in_run, prod_vld_reg, (state_reg == imm_pkg::ST_ISSUE) || (state_reg == imm_pkg::ST_DRAIN), "product outside run")
    // A taken non-final result restarts the term walk at k zero
    `IMM_ASSERT_NEXT(a_next_elem, result_valid && result_ready && !last, (state_reg == imm_pkg::ST_ISSUE) && (k_reg == '0), "bad restart after result")

endmodule

### dv/tb_top.sv
// Testbench for the integer matrix multiplier: loads A and B, runs products, checks results.
// Depends on imm_pkg and the integer_matrix_multiply top level; needs no other files.
`timescale 1ns / 1ps

module tb_top;

    localparam int          MAX_DIM      = 8;
    localparam logic [1:0]  ACT_NONE     = 2'd3;
    localparam int          RAND_ITEMS   = 100;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          TIMEOUT_NS   = 50_000_000;
    localparam logic [31:0] WORD_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
    } product_t;

    // Predicts product elements and checks them in order of arrival
    class product_scoreboard;
        logic [31:0]    a_grid [MAX_DIM][MAX_DIM];
        logic [31:0]    b_grid [MAX_DIM][MAX_DIM];
        logic [imm_pkg::DIM_W-1:0] dim_reg [3];
        product_t       pending_products [$];
        int             failures;

        function new();
            dim_reg[imm_pkg::CFG_ROWS_A]    = 4'd8;
            dim_reg[imm_pkg::CFG_INNER_DIM] = 4'd8;
            dim_reg[imm_pkg::CFG_COLS_B]    = 4'd8;
            failures = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [imm_pkg::DIM_W-1:0] val);
            dim_reg[idx] = val;
        endfunction

        // Zero acts as one, anything above the maximum acts as the maximum
        function int eff_dim(logic [1:0] idx);
            if (dim_reg[idx] == 0)
                return 1;
            if (dim_reg[idx] > MAX_DIM)
                return MAX_DIM;
            return int'(dim_reg[idx]);
        endfunction

        function int outstanding();
            return pending_products.size();
        endfunction

        // Apply one accepted item: store an element or queue the whole product
        function void note_item(logic [1:0] act, logic [2:0] row, logic [2:0] col,
                                logic [31:0] val);
            int nr;
            int nk;
            int nc;
            logic [31:0] acc;
            product_t p;
            if (act == imm_pkg::ACT_WR_A)
                a_grid[row][col] = val;
            else if (act == imm_pkg::ACT_WR_B)
                b_grid[row][col] = val;
            else if (act == imm_pkg::ACT_COMPUTE)
            begin
                nr = eff_dim(imm_pkg::CFG_ROWS_A);
                nk = eff_dim(imm_pkg::CFG_INNER_DIM);
                nc = eff_dim(imm_pkg::CFG_COLS_B);
                for (int i = 0; i < nr; i++)
                begin
                    for (int j = 0; j < nc; j++)
                    begin
                        acc = '0;
                        for (int k = 0; k < nk; k++)
                            acc = acc + a_grid[i][k] * b_grid[k][j];
                        p.row   = 3'(i);
                        p.col   = 3'(j);
                        p.value = acc;
                        p.last  = (i == nr - 1) && (j == nc - 1);
                        pending_products.push_back(p);
                    end
                end
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(product_t got);
            product_t want;
            if (pending_products.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result row %0d col %0d value %h last %b",
                             $realtime, got.row, got.col, got.value, got.last);
                return;
            end
            want = pending_products.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.value !== want.value || got.last !== want.last)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch exp r%0d c%0d %h last %b, got r%0d c%0d %h last %b",
                             $realtime, want.row, want.col, want.value, want.last,
                             got.row, got.col, got.value, got.last);
            end
        endfunction
    endclass

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_wr_en     = 1'b0;
    logic [1:0]                cfg_index     = imm_pkg::CFG_ROWS_A;
    logic [imm_pkg::DIM_W-1:0] cfg_data      = '0;
    logic                      item_valid    = 1'b0;
    logic                      item_ready;
    logic [1:0]                action        = imm_pkg::ACT_WR_A;
    logic [2:0]                row_index     = '0;
    logic [2:0]                col_index     = '0;
    logic signed [imm_pkg::DATA_W-1:0] element_value = '0;
    logic                      result_valid;
    logic                      result_ready  = 1'b0;
    logic [2:0]                out_row;
    logic [2:0]                out_col;
    logic signed [imm_pkg::DATA_W-1:0] product_value;
    logic                      last;

    product_scoreboard sb = new();

    bit a_written [MAX_DIM][MAX_DIM];
    bit b_written [MAX_DIM][MAX_DIM];
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_stall_left = 0;
    int rand_items = 0;

    integer_matrix_multiply #(.MAX_DIM(MAX_DIM)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .action        (action),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last          (last)
    );

    always #5 clk = ~clk;

    // Pause length: mostly short, a few long
    function automatic int pick_pause();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return WORD_MIN_NEG;
            1: return WORD_MAX_POS;
            2: return '0;
            3: return '1;
            4: return 32'($signed($urandom_range(0, 31)) - 16);
            default: return $urandom;
        endcase
    endfunction

    // Dimension register value: mostly small, sometimes out of range or full
    function automatic logic [imm_pkg::DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return imm_pkg::DIM_W'($urandom_range(1, 4));
        if (r == 7)
            return '0;
        if (r == 8)
            return imm_pkg::DIM_W'(MAX_DIM);
        return imm_pkg::DIM_W'($urandom_range(9, 15));
    endfunction

    // Receiver: stall at random, or take every result in steady stretches
    always @(posedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            result_ready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end
        else if (!rx_steady && $urandom_range(0, 3) == 0)
        begin
            result_ready <= 1'b0;
            rx_stall_left = pick_pause() - 1;
        end
        else
            result_ready <= 1'b1;
    end

    // Sample both channels mid-cycle; a handshake seen here completes at the next edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_item(action, row_index, col_index, element_value);
            if (result_valid && result_ready)
                sb.check_result('{out_row, out_col, product_value, last});
        end
    end

    // Offer one item after an optional gap and hold it until taken
    task automatic send_item(logic [1:0] act, logic [2:0] row, logic [2:0] col,
                             logic [31:0] val);
        int gap;
        gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_pause();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        action        <= act;
        row_index     <= row;
        col_index     <= col;
        element_value <= val;
        do
            @(negedge clk);
        while (!item_ready);
        @(posedge clk);
    endtask

    task automatic load_elem(logic [1:0] act, logic [2:0] row, logic [2:0] col,
                             logic [31:0] val);
        send_item(act, row, col, val);
        if (act == imm_pkg::ACT_WR_A)
            a_written[row][col] = 1'b1;
        else
            b_written[row][col] = 1'b1;
    endtask

    task automatic compute();
        send_item(imm_pkg::ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
    endtask

    // Hold off intake until every queued product element has come back
    task automatic drain_products();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic quiesce();
        drain_products();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(logic [imm_pkg::DIM_W-1:0] r, logic [imm_pkg::DIM_W-1:0] k,
                            logic [imm_pkg::DIM_W-1:0] c);
        cfg_wr_en <= 1'b1;
        cfg_index <= imm_pkg::CFG_ROWS_A;
        cfg_data  <= r;
        @(posedge clk);
        sb.write_reg(imm_pkg::CFG_ROWS_A, r);
        cfg_index <= imm_pkg::CFG_INNER_DIM;
        cfg_data  <= k;
        @(posedge clk);
        sb.write_reg(imm_pkg::CFG_INNER_DIM, k);
        cfg_index <= imm_pkg::CFG_COLS_B;
        cfg_data  <= c;
        @(posedge clk);
        sb.write_reg(imm_pkg::CFG_COLS_B, c);
        cfg_wr_en <= 1'b0;
    endtask

    // Write every element the next product reads that is still unwritten
    task automatic fill_operands();
        int nr;
        int nk;
        int nc;
        nr = sb.eff_dim(imm_pkg::CFG_ROWS_A);
        nk = sb.eff_dim(imm_pkg::CFG_INNER_DIM);
        nc = sb.eff_dim(imm_pkg::CFG_COLS_B);
        for (int i = 0; i < nr; i++)
            for (int k = 0; k < nk; k++)
                if (!a_written[i][k])
                begin
                    load_elem(imm_pkg::ACT_WR_A, 3'(i), 3'(k), pick_value());
                    rand_items++;
                end
        for (int k = 0; k < nk; k++)
            for (int j = 0; j < nc; j++)
                if (!b_written[k][j])
                begin
                    load_elem(imm_pkg::ACT_WR_B, 3'(k), 3'(j), pick_value());
                    rand_items++;
                end
    endtask

    // Random loads with a little noise in between
    task automatic random_loads();
        int n;
        n = $urandom_range(2, 10);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(ACT_NONE, 3'($urandom), 3'($urandom), $urandom);
            else
            begin
                load_elem($urandom_range(0, 1) ? imm_pkg::ACT_WR_B : imm_pkg::ACT_WR_A,
                          3'($urandom), 3'($urandom), pick_value());
                rand_items++;
            end
        end
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int phase_no;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: overflow on a 1x1 product, extremes of the value
        set_dims(4'd1, 4'd1, 4'd1);
        load_elem(imm_pkg::ACT_WR_A, 3'd0, 3'd0, WORD_MAX_POS);
        load_elem(imm_pkg::ACT_WR_B, 3'd0, 3'd0, WORD_MAX_POS);
        compute();
        load_elem(imm_pkg::ACT_WR_A, 3'd0, 3'd0, WORD_MIN_NEG);
        load_elem(imm_pkg::ACT_WR_B, 3'd0, 3'd0, '1);
        compute();
        // Unused action does nothing
        send_item(ACT_NONE, 3'd7, 3'd7, '1);
        send_item(ACT_NONE, 3'd0, 3'd0, '0);
        compute();
        // Zero dimensions act as one
        quiesce();
        set_dims(4'd0, 4'd0, 4'd0);
        compute();
        // Highest indexes, then a 2x2 product with an inner size of 2
        load_elem(imm_pkg::ACT_WR_A, 3'd7, 3'd7, '0);
        load_elem(imm_pkg::ACT_WR_B, 3'd7, 3'd7, WORD_MIN_NEG);
        quiesce();
        set_dims(4'd2, 4'd2, 4'd2);
        load_elem(imm_pkg::ACT_WR_A, 3'd0, 3'd1, WORD_MIN_NEG);
        load_elem(imm_pkg::ACT_WR_A, 3'd1, 3'd0, 32'd3);
        load_elem(imm_pkg::ACT_WR_A, 3'd1, 3'd1, WORD_MAX_POS);
        load_elem(imm_pkg::ACT_WR_B, 3'd0, 3'd1, 32'hFFFF_FFFE);
        load_elem(imm_pkg::ACT_WR_B, 3'd1, 3'd0, WORD_MIN_NEG);
        load_elem(imm_pkg::ACT_WR_B, 3'd1, 3'd1, 32'd2);
        compute();

        // Random phases; the first two use out-of-range dimensions
        phase_no = 0;
        while (rand_items < RAND_ITEMS)
        begin
            quiesce();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (phase_no == 0)
                set_dims(4'd15, 4'd1, 4'd15);
            else if (phase_no == 1)
                set_dims(4'd1, 4'd15, 4'd1);
            else
                set_dims(pick_dim(), pick_dim(), pick_dim());
            random_loads();
            fill_operands();
            compute();
            rand_items++;
            if (phase_no == 0 || $urandom_range(0, 1) == 0)
            begin
                if (phase_no == 0 || $urandom_range(0, 1) == 0)
                    drain_products();
                random_loads();
                fill_operands();
                compute();
                rand_items++;
            end
            phase_no++;
        end

        // Wait out the last products
        drain_products();
        repeat (SETTLE_CYCLES + 4) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/imm_pkg.sv
rtl/imm_ram.sv
rtl/integer_matrix_multiply.sv
dv/tb_top.sv
